### rtl/cmwa_pkg.sv
// Shared constants, types and register codes for the sample conditioner.
package cmwa_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int WEIGHT_W     = 8;
    localparam int TAPS_AVG     = 4;
    localparam int TAPS_MED     = 3;
    // Weight total: four 8-bit weights
    localparam int TOT_W        = WEIGHT_W + $clog2(TAPS_AVG);
    // Weighted sum, signed
    localparam int SUM_W        = SAMPLE_WIDTH + TOT_W;
    localparam int CNT_W        = $clog2(SAMPLE_WIDTH + 1);
    localparam int CFG_IDX_W    = 3;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic [WEIGHT_W-1:0]            weight_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_LEVEL     = 3'd0,
        CFG_MAX_LEVEL     = 3'd1,
        CFG_WEIGHT_NEWEST = 3'd2,
        CFG_WEIGHT_SECOND = 3'd3,
        CFG_WEIGHT_THIRD  = 3'd4,
        CFG_WEIGHT_OLDEST = 3'd5
    } cmwa_reg_t;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  dividend;
        logic [TOT_W-1:0]  divisor;
    } cmwa_div_req_t;

    typedef struct packed {
        logic                    done;
        logic [SAMPLE_WIDTH-1:0] quotient;
    } cmwa_div_rsp_t;

endpackage

### rtl/cmwa_ifs.sv
// Channel interfaces: sample input, result output, configuration write.
interface cmwa_sample_if import cmwa_pkg::*;;
    logic    valid;
    logic    ready;
    sample_t raw_sample;

    modport source (output valid, output raw_sample, input ready);
    modport sink   (input valid, input raw_sample, output ready);
endinterface

interface cmwa_result_if import cmwa_pkg::*;;
    logic    valid;
    logic    ready;
    sample_t raw_echo;
    sample_t clamped_sample;
    sample_t median_sample;
    sample_t weighted_sample;
    logic    settled;

    modport source (output valid, output raw_echo, output clamped_sample,
                    output median_sample, output weighted_sample, output settled,
                    input ready);
    modport sink   (input valid, input raw_echo, input clamped_sample,
                    input median_sample, input weighted_sample, input settled,
                    output ready);
endinterface

interface cmwa_cfg_if import cmwa_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_W-1:0]    index;
    logic [SAMPLE_WIDTH-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/cmwa_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module cmwa_div import cmwa_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cmwa_div_req_t req,
    output cmwa_div_rsp_t rsp
);

    logic                    busy_reg;
    logic                    done_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [TOT_W-1:0]        rem_reg;
    logic [SAMPLE_WIDTH-1:0] quo_reg;
    logic [TOT_W-1:0]        divisor_reg;

    logic [TOT_W:0]          trial;
    logic [TOT_W:0]          diff;
    logic                    q_bit;
    logic [TOT_W-1:0]        rem_next;

    // Quotient fits the sample width, so the top bits of the dividend
    // start below the divisor and only SAMPLE_WIDTH steps are needed.
    always_comb
    begin
        trial = {rem_reg, quo_reg[SAMPLE_WIDTH-1]};
        diff  = trial - {1'b0, divisor_reg};
        q_bit = ~diff[TOT_W];
        rem_next = q_bit ? diff[TOT_W-1:0] : trial[TOT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            count_reg   <= '0;
            rem_reg     <= '0;
            quo_reg     <= '0;
            divisor_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg    <= 1'b1;
                count_reg   <= '0;
                rem_reg     <= req.dividend[SUM_W-1:SAMPLE_WIDTH];
                quo_reg     <= req.dividend[SAMPLE_WIDTH-1:0];
                divisor_reg <= req.divisor;
            end
            else if (busy_reg)
            begin
                rem_reg   <= rem_next;
                quo_reg   <= {quo_reg[SAMPLE_WIDTH-2:0], q_bit};
                count_reg <= count_reg + 1'b1;
                if (count_reg == CNT_W'(SAMPLE_WIDTH - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### rtl/clamp_median3_weighted_average_core.sv
// Sample conditioner top level: clamp, 3-point median, 4-tap weighted average.
//
// Each transfer on sample_in is clamped to [min_level, max_level], fed to a
// 3-entry median filter (pass-through until three samples have arrived) and
// then to a 4-tap weighted moving average (pass-through until it holds four
// medians, or whenever the weights sum to zero). Exactly one transfer on
// result_out follows each input. While the average is still filling or the
// weight total is zero, an accepted sample goes from the idle state straight
// to the result step. Once settled, each item runs through one multiply-
// accumulate step per tap on a single multiplier, a setup step that starts
// the divider, the bit-serial divider that forms the quotient (truncated
// toward zero), a step to capture the quotient and a step to load the result
// register. A full result register that is not drained stalls the sequencer
// in its last step. sample_in.ready is high only while the sequencer is idle;
// a finished result sits in the output register so the next sample can be
// taken before it is drained. Configuration writes are always ready and must
// only be issued while the block is idle; unknown register indexes are ignored.
module clamp_median3_weighted_average_core import cmwa_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    cmwa_sample_if.sink     sample_in,
    cmwa_result_if.source   result_out,
    cmwa_cfg_if.sink        cfg
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_SETUP,
        ST_DIV,
        ST_RESULT
    } state_t;

    state_t state_reg;

    // Configuration
    sample_t min_level_reg;
    sample_t max_level_reg;
    weight_t weight_reg [TAPS_AVG];

    // Filter state; windows are left unreset, fill counts guard them
    sample_t    med_win_reg [TAPS_MED];
    logic [1:0] med_slot_reg;
    logic [1:0] med_fill_reg;
    sample_t    avg_win_reg [TAPS_AVG];
    logic [1:0] avg_slot_reg;
    logic [2:0] avg_fill_reg;
    logic       settled_reg;

    // Per-item holding
    sample_t                 raw_hold_reg;
    sample_t                 clamp_hold_reg;
    sample_t                 med_hold_reg;
    sample_t                 wavg_hold_reg;
    logic [1:0]              age_reg;
    logic signed [SUM_W-1:0] acc_reg;
    logic                    neg_reg;

    // Output register
    logic    out_valid_reg;
    sample_t out_raw_reg;
    sample_t out_clamp_reg;
    sample_t out_med_reg;
    sample_t out_wavg_reg;
    logic    out_settled_reg;

    function automatic sample_t median3(sample_t a, sample_t b, sample_t c);
        sample_t lo;
        sample_t hi;
        sample_t m;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        m  = (hi < c) ? hi : c;
        return (lo > m) ? lo : m;
    endfunction

    // ---------------------------------------------------------------
    // Front end, evaluated in the accept cycle
    // ---------------------------------------------------------------
    logic       in_xfer;
    sample_t    clamped;
    sample_t    med_e [TAPS_MED];
    logic [1:0] med_fill_next;
    logic [1:0] med_slot_next;
    sample_t    med_value;
    logic [2:0] avg_fill_next;
    logic [TOT_W-1:0] weight_total;

    assign in_xfer = sample_in.valid && sample_in.ready;

    always_comb
    begin
        if (sample_in.raw_sample < min_level_reg)
            clamped = min_level_reg;
        else if (sample_in.raw_sample > max_level_reg)
            clamped = max_level_reg;
        else
            clamped = sample_in.raw_sample;

        for (int i = 0; i < TAPS_MED; i++)
            med_e[i] = (med_slot_reg == 2'(i)) ? clamped : med_win_reg[i];

        med_fill_next = (med_fill_reg < 2'(TAPS_MED)) ? med_fill_reg + 2'd1 : med_fill_reg;
        med_slot_next = (med_slot_reg == 2'(TAPS_MED - 1)) ? 2'd0 : med_slot_reg + 2'd1;
        med_value = (med_fill_next < 2'(TAPS_MED)) ? clamped
                                                   : median3(med_e[0], med_e[1], med_e[2]);

        avg_fill_next = (avg_fill_reg < 3'(TAPS_AVG)) ? avg_fill_reg + 3'd1 : avg_fill_reg;

        weight_total = TOT_W'(weight_reg[0]) + TOT_W'(weight_reg[1])
                     + TOT_W'(weight_reg[2]) + TOT_W'(weight_reg[3]);
    end

    // ---------------------------------------------------------------
    // Multiply-accumulate step: newest median sits one slot behind
    // the write pointer, older ones further back
    // ---------------------------------------------------------------
    logic [1:0]              mac_idx;
    logic signed [SUM_W-1:0] mac_sample;
    logic signed [SUM_W-1:0] mac_weight;
    logic signed [SUM_W-1:0] mac_prod;
    logic signed [SUM_W-1:0] acc_next;
    logic [SUM_W-1:0]        acc_mag;
    sample_t                 quo_signed;

    always_comb
    begin
        mac_idx    = avg_slot_reg - 2'd1 - age_reg;
        mac_sample = {{(SUM_W-SAMPLE_WIDTH){avg_win_reg[mac_idx][SAMPLE_WIDTH-1]}},
                      avg_win_reg[mac_idx]};
        mac_weight = {{(SUM_W-WEIGHT_W){1'b0}}, weight_reg[age_reg]};
        mac_prod   = mac_sample * mac_weight;
        acc_next   = acc_reg + mac_prod;
        acc_mag    = acc_reg[SUM_W-1] ? (~acc_reg + 1'b1) : acc_reg;
    end

    // ---------------------------------------------------------------
    // Divider instance
    // ---------------------------------------------------------------
    cmwa_div_req_t div_req;
    cmwa_div_rsp_t div_rsp;

    assign div_req.start    = (state_reg == ST_SETUP);
    assign div_req.dividend = acc_mag;
    assign div_req.divisor  = weight_total;

    cmwa_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign quo_signed = neg_reg ? sample_t'(~div_rsp.quotient + 1'b1)
                                : sample_t'(div_rsp.quotient);

    // ---------------------------------------------------------------
    // Window storage
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            med_win_reg[med_slot_reg] <= clamped;
            avg_win_reg[avg_slot_reg] <= med_value;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer, configuration and output register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            min_level_reg   <= {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
            max_level_reg   <= {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
            for (int i = 0; i < TAPS_AVG; i++)
                weight_reg[i] <= WEIGHT_W'(1);
            med_slot_reg    <= '0;
            med_fill_reg    <= '0;
            avg_slot_reg    <= '0;
            avg_fill_reg    <= '0;
            settled_reg     <= 1'b0;
            raw_hold_reg    <= '0;
            clamp_hold_reg  <= '0;
            med_hold_reg    <= '0;
            wavg_hold_reg   <= '0;
            age_reg         <= '0;
            acc_reg         <= '0;
            neg_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_raw_reg     <= '0;
            out_clamp_reg   <= '0;
            out_med_reg     <= '0;
            out_wavg_reg    <= '0;
            out_settled_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_MIN_LEVEL:     min_level_reg <= cfg.data;
                    CFG_MAX_LEVEL:     max_level_reg <= cfg.data;
                    CFG_WEIGHT_NEWEST: weight_reg[0] <= cfg.data[WEIGHT_W-1:0];
                    CFG_WEIGHT_SECOND: weight_reg[1] <= cfg.data[WEIGHT_W-1:0];
                    CFG_WEIGHT_THIRD:  weight_reg[2] <= cfg.data[WEIGHT_W-1:0];
                    CFG_WEIGHT_OLDEST: weight_reg[3] <= cfg.data[WEIGHT_W-1:0];
                    default:           ;
                endcase
            end

            // In ST_RESULT a drained slot is refilled below instead
            if (result_out.valid && result_out.ready && state_reg != ST_RESULT)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        med_slot_reg   <= med_slot_next;
                        med_fill_reg   <= med_fill_next;
                        avg_slot_reg   <= avg_slot_reg + 2'd1;
                        avg_fill_reg   <= avg_fill_next;
                        if (med_fill_next == 2'(TAPS_MED))
                            settled_reg <= 1'b1;
                        raw_hold_reg   <= sample_in.raw_sample;
                        clamp_hold_reg <= clamped;
                        med_hold_reg   <= med_value;
                        wavg_hold_reg  <= med_value;
                        age_reg        <= '0;
                        acc_reg        <= '0;
                        // Pass-through while filling or with zero weight total
                        if (avg_fill_next < 3'(TAPS_AVG) || weight_total == '0)
                            state_reg <= ST_RESULT;
                        else
                            state_reg <= ST_MAC;
                    end
                end

                ST_MAC:
                begin
                    acc_reg <= acc_next;
                    age_reg <= age_reg + 2'd1;
                    if (age_reg == 2'(TAPS_AVG - 1))
                        state_reg <= ST_SETUP;
                end

                ST_SETUP:
                begin
                    neg_reg   <= acc_reg[SUM_W-1];
                    state_reg <= ST_DIV;
                end

                ST_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        wavg_hold_reg <= quo_signed;
                        state_reg     <= ST_RESULT;
                    end
                end

                ST_RESULT:
                begin
                    if (!out_valid_reg || result_out.ready)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_raw_reg     <= raw_hold_reg;
                        out_clamp_reg   <= clamp_hold_reg;
                        out_med_reg     <= med_hold_reg;
                        out_wavg_reg    <= wavg_hold_reg;
                        out_settled_reg <= settled_reg;
                        state_reg       <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign sample_in.ready = (state_reg == ST_IDLE);
    assign cfg.ready       = 1'b1;

    assign result_out.valid           = out_valid_reg;
    assign result_out.raw_echo        = out_raw_reg;
    assign result_out.clamped_sample  = out_clamp_reg;
    assign result_out.median_sample   = out_med_reg;
    assign result_out.weighted_sample = out_wavg_reg;
    assign result_out.settled         = out_settled_reg;

endmodule
